FILE: src/qtds_pkg.sv
// shared types, codes and widths for the query term document statistics block
`timescale 1ns / 1ps

package qtds_pkg;

	localparam int MAX_QUERY_TERMS_DEF = 64;
	localparam int FRACTION_BITS_DEF   = 16;

	localparam int COUNT_W    = 16;
	localparam int IDF_W      = 16;
	localparam int LENGTH_W   = 24;
	localparam int TERMS_W    = 7;
	localparam int RATIO_W    = 17;
	localparam int VALUE_W    = 64;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - TERMS_W - RATIO_W - 1;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// shared divider: 64-bit dividend, divisor up to document length plus one
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = LENGTH_W + 1;
	localparam int ITER_W     = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHTING_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATISTIC_SELECT = 2'd1;

	localparam logic [1:0] WMODE_RAW = 2'd0;
	localparam logic [1:0] WMODE_LEN = 2'd1;
	localparam logic [1:0] WMODE_IDF = 2'd2;

	localparam logic [2:0] STAT_SUM  = 3'd0;
	localparam logic [2:0] STAT_MIN  = 3'd1;
	localparam logic [2:0] STAT_MAX  = 3'd2;
	localparam logic [2:0] STAT_VAR  = 3'd3;
	localparam logic [2:0] STAT_MEAN = 3'd4;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} qtds_div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_GO,
		ST_W_DIV,
		ST_W_MUL,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_FIN,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_VMUL_GO,
		ST_VMUL_WAIT,
		ST_VDIV_GO,
		ST_VDIV_WAIT,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_EMIT
	} qtds_state_t;

endpackage

FILE: src/qtds_div.sv
// restoring radix-2 divider, one quotient bit per cycle, variable bit count
`timescale 1ns / 1ps

module qtds_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qtds_pkg::qtds_div_req_t                req,
	input  logic [qtds_pkg::DIVIDEND_W-1:0]        dividend,
	input  logic [qtds_pkg::DIVISOR_W-1:0]         divisor,
	output logic                                   done,
	output logic [qtds_pkg::DIVIDEND_W-1:0]        quotient
);

	localparam int NW = qtds_pkg::DIVIDEND_W;
	localparam int DW = qtds_pkg::DIVISOR_W;
	localparam int IW = qtds_pkg::ITER_W;

	logic          busy_q;
	logic [IW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dsr_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;
	logic [IW-1:0] align;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};
	// dividend bits are moved to the top so that only iters steps are needed
	assign align = IW'(NW) - req.iters;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend << align;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/qtds_mul.sv
// 64 x 64 multiplier built from one 32 x 32 multiplier over four partial products
`timescale 1ns / 1ps

module qtds_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] product
);

	logic         run_q;
	logic [1:0]   step_q;
	logic         pv_s1;
	logic         last_s1;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  prod_s1;
	logic [1:0]   shift_s1;
	logic [127:0] acc_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;

	assign a_half = step_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp     = a_half * b_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				pv_s1  <= 1'b0;
			end else begin
				pv_s1   <= run_q;
				last_s1 <= run_q && (step_q == 2'd3);
				if (run_q) begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						run_q <= 1'b0;
					end
				end
				if (pv_s1 && last_s1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (run_q) begin
				prod_s1  <= pp;
				shift_s1 <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			end
			// partial product weight is 2^(32 * (high halves taken))
			if (pv_s1) begin
				acc_q <= acc_q + ({64'b0, prod_s1} << {shift_s1, 5'b0});
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

FILE: src/query_term_document_statistics.sv
// top level: sequencer, per-document accumulators and stream ports
`timescale 1ns / 1ps

// One item is accepted, then the block is busy until that item is folded into
// the running sum, sum of squares, minimum, maximum and nonzero count. The
// busy time is set by the shared radix-2 divider (one quotient bit per cycle)
// and the shared 32 x 32 multiplier (four partial products): a raw weight
// needs one product for its square, an idf weight two products, and a
// length-normalized weight a division and a product. On the term marked
// tlast the result adds a division for the present ratio, one more for the
// mean, and a product and a division more for the sample variance. A result
// waits in the output register while the next document is taken in. Items
// past MAX_QUERY_TERMS in one document are dropped from the statistics, but
// their tlast still closes the document. Configuration writes are taken at
// any time and must only be issued while the block is idle.
module query_term_document_statistics #(
	parameter int MAX_QUERY_TERMS = qtds_pkg::MAX_QUERY_TERMS_DEF,
	parameter int FRACTION_BITS   = qtds_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// term_count [15:0], term_idf [31:16], document_length [55:32]
	input  logic [qtds_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// statistic_value [63:0], terms_present [70:64], present_ratio [87:71],
	// saturated [88], zero [95:89]
	output logic [qtds_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qtds_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [qtds_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = qtds_pkg::COUNT_W;
	localparam int LW = qtds_pkg::LENGTH_W;
	localparam int TW = qtds_pkg::TERMS_W;
	localparam int RW = qtds_pkg::RATIO_W;
	localparam int VW = qtds_pkg::VALUE_W;
	localparam int DW = qtds_pkg::DIVISOR_W;
	localparam int IW = qtds_pkg::ITER_W;

	localparam logic [TW-1:0] MAX_TERMS   = TW'(MAX_QUERY_TERMS);
	localparam logic [IW-1:0] WDIV_ITERS  = IW'(CW + FRACTION_BITS);
	localparam logic [IW-1:0] FULL_ITERS  = IW'(qtds_pkg::DIVIDEND_W);
	localparam logic [IW-1:0] RATIO_ITERS = IW'(TW + 16);

	qtds_pkg::qtds_state_t state_q, state_d;

	logic [1:0]    weighting_mode_q;
	logic [2:0]    statistic_select_q;

	logic [CW-1:0] count_q;
	logic [15:0]   idf_q;
	logic [LW-1:0] length_q;
	logic          last_q;

	logic [VW-1:0] w_q;
	logic [VW-1:0] sum_q;
	logic [VW-1:0] sqsum_q;
	logic [VW-1:0] min_q;
	logic [VW-1:0] max_q;
	logic [TW-1:0] seen_q;
	logic [TW-1:0] nonzero_q;
	logic          clip_q;

	logic [VW-1:0] value_q;
	logic [RW-1:0] ratio_q;

	logic          m_tvalid_q;
	logic [VW-1:0] value_out_q;
	logic [TW-1:0] present_out_q;
	logic [RW-1:0] ratio_out_q;
	logic          sat_out_q;

	qtds_pkg::qtds_div_req_t div_req;
	logic [VW-1:0]  div_dividend;
	logic [DW-1:0]  div_divisor;
	logic           div_done;
	logic [VW-1:0]  div_quo;

	logic           mul_start;
	logic [63:0]    mul_a;
	logic [63:0]    mul_b;
	logic           mul_done;
	logic [127:0]   mul_prod;

	logic [127:0]   prod_shift;
	logic           frac_sat;
	logic [VW-1:0]  frac_val;
	logic [VW:0]    sum_ext;
	logic [VW:0]    sq_ext;
	logic [TW-1:0]  n_w;
	logic [TW-1:0]  n_m1;
	logic           s_accept;
	logic           out_free;

	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign n_w      = (seen_q == '0) ? TW'(1) : seen_q;
	assign n_m1     = n_w - TW'(1);

	// floor(a * b >> FRACTION_BITS), clipped to 64 bits
	assign prod_shift = mul_prod >> FRACTION_BITS;
	assign frac_sat   = |prod_shift[127:VW];
	assign frac_val   = frac_sat ? '1 : prod_shift[VW-1:0];
	assign sum_ext    = {1'b0, sum_q} + {1'b0, w_q};
	assign sq_ext     = {1'b0, sqsum_q} + {1'b0, frac_val};

	qtds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	qtds_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qtds_pkg::ST_IDLE: begin
				if (s_accept) begin
					if (seen_q < MAX_TERMS) begin
						state_d = qtds_pkg::ST_W_GO;
					end else if (s_tlast) begin
						state_d = qtds_pkg::ST_FIN;
					end
				end
			end
			qtds_pkg::ST_W_GO: begin
				unique case (weighting_mode_q)
					qtds_pkg::WMODE_LEN: state_d = qtds_pkg::ST_W_DIV;
					qtds_pkg::WMODE_IDF: state_d = qtds_pkg::ST_W_MUL;
					default:             state_d = qtds_pkg::ST_SQ_GO;
				endcase
			end
			qtds_pkg::ST_W_DIV: begin
				if (div_done) begin
					state_d = qtds_pkg::ST_SQ_GO;
				end
			end
			qtds_pkg::ST_W_MUL: begin
				if (mul_done) begin
					state_d = qtds_pkg::ST_SQ_GO;
				end
			end
			qtds_pkg::ST_SQ_GO: state_d = qtds_pkg::ST_SQ_WAIT;
			qtds_pkg::ST_SQ_WAIT: begin
				if (mul_done) begin
					state_d = last_q ? qtds_pkg::ST_FIN : qtds_pkg::ST_IDLE;
				end
			end
			qtds_pkg::ST_FIN: begin
				unique case (statistic_select_q)
					qtds_pkg::STAT_MEAN: state_d = qtds_pkg::ST_AVG_GO;
					qtds_pkg::STAT_VAR: begin
						state_d = (n_w > TW'(1)) ? qtds_pkg::ST_AVG_GO : qtds_pkg::ST_RATIO_GO;
					end
					default: state_d = qtds_pkg::ST_RATIO_GO;
				endcase
			end
			qtds_pkg::ST_AVG_GO: state_d = qtds_pkg::ST_AVG_WAIT;
			qtds_pkg::ST_AVG_WAIT: begin
				if (div_done) begin
					state_d = (statistic_select_q == qtds_pkg::STAT_VAR) ?
						qtds_pkg::ST_VMUL_GO : qtds_pkg::ST_RATIO_GO;
				end
			end
			qtds_pkg::ST_VMUL_GO: state_d = qtds_pkg::ST_VMUL_WAIT;
			qtds_pkg::ST_VMUL_WAIT: begin
				if (mul_done) begin
					state_d = qtds_pkg::ST_VDIV_GO;
				end
			end
			qtds_pkg::ST_VDIV_GO: state_d = qtds_pkg::ST_VDIV_WAIT;
			qtds_pkg::ST_VDIV_WAIT: begin
				if (div_done) begin
					state_d = qtds_pkg::ST_RATIO_GO;
				end
			end
			qtds_pkg::ST_RATIO_GO: state_d = qtds_pkg::ST_RATIO_WAIT;
			qtds_pkg::ST_RATIO_WAIT: begin
				if (div_done) begin
					state_d = qtds_pkg::ST_EMIT;
				end
			end
			qtds_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = qtds_pkg::ST_IDLE;
				end
			end
			default: state_d = qtds_pkg::ST_IDLE;
		endcase
	end

	// unit launches and operand selection
	always_comb begin
		s_tready      = 1'b0;
		div_req.start = 1'b0;
		div_req.iters = FULL_ITERS;
		div_dividend  = sum_q;
		div_divisor   = DW'(n_w);
		mul_start     = 1'b0;
		mul_a         = w_q;
		mul_b         = w_q;
		unique case (state_q)
			qtds_pkg::ST_IDLE: s_tready = 1'b1;
			qtds_pkg::ST_W_GO: begin
				div_req.start = (weighting_mode_q == qtds_pkg::WMODE_LEN);
				div_req.iters = WDIV_ITERS;
				div_dividend  = VW'(count_q) << FRACTION_BITS;
				div_divisor   = {1'b0, length_q} + DW'(1);
				mul_start     = (weighting_mode_q == qtds_pkg::WMODE_IDF);
				mul_a         = 64'(count_q);
				mul_b         = 64'(idf_q);
			end
			qtds_pkg::ST_SQ_GO: mul_start = 1'b1;
			qtds_pkg::ST_AVG_GO: div_req.start = 1'b1;
			qtds_pkg::ST_VMUL_GO: begin
				mul_start = 1'b1;
				mul_a     = value_q;
				mul_b     = sum_q;
			end
			qtds_pkg::ST_VDIV_GO: begin
				div_req.start = 1'b1;
				div_dividend  = value_q;
				div_divisor   = DW'(n_m1);
			end
			qtds_pkg::ST_RATIO_GO: begin
				div_req.start = 1'b1;
				div_req.iters = RATIO_ITERS;
				div_dividend  = VW'({nonzero_q, 16'b0});
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= qtds_pkg::ST_IDLE;
			weighting_mode_q   <= qtds_pkg::WMODE_RAW;
			statistic_select_q <= qtds_pkg::STAT_SUM;
			sum_q              <= '0;
			sqsum_q            <= '0;
			min_q              <= '1;
			max_q              <= '0;
			seen_q             <= '0;
			nonzero_q          <= '0;
			clip_q             <= 1'b0;
			m_tvalid_q         <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				unique case (cfg_index)
					qtds_pkg::CFG_WEIGHTING_MODE:   weighting_mode_q   <= cfg_data[1:0];
					qtds_pkg::CFG_STATISTIC_SELECT: statistic_select_q <= cfg_data[2:0];
					default: ;
				endcase
			end

			if (state_q == qtds_pkg::ST_SQ_WAIT && mul_done) begin
				sum_q   <= sum_ext[VW] ? '1 : sum_ext[VW-1:0];
				sqsum_q <= sq_ext[VW] ? '1 : sq_ext[VW-1:0];
				if (w_q < min_q) begin
					min_q <= w_q;
				end
				if (w_q > max_q) begin
					max_q <= w_q;
				end
				seen_q <= seen_q + TW'(1);
				if (count_q != '0) begin
					nonzero_q <= nonzero_q + TW'(1);
				end
				clip_q <= clip_q | sum_ext[VW] | sq_ext[VW] | frac_sat;
			end

			// clipping of the mean times sum product counts too
			if (state_q == qtds_pkg::ST_VMUL_WAIT && mul_done && frac_sat) begin
				clip_q <= 1'b1;
			end

			if (state_q == qtds_pkg::ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
				sum_q      <= '0;
				sqsum_q    <= '0;
				min_q      <= '1;
				max_q      <= '0;
				seen_q     <= '0;
				nonzero_q  <= '0;
				clip_q     <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			count_q  <= s_tdata[15:0];
			idf_q    <= s_tdata[31:16];
			length_q <= s_tdata[55:32];
			last_q   <= s_tlast;
		end

		if (state_q == qtds_pkg::ST_W_GO) begin
			w_q <= VW'(count_q) << FRACTION_BITS;
		end else if (state_q == qtds_pkg::ST_W_DIV && div_done) begin
			w_q <= div_quo;
		end else if (state_q == qtds_pkg::ST_W_MUL && mul_done) begin
			w_q <= mul_prod[VW-1:0] << (FRACTION_BITS - 8);
		end

		if (state_q == qtds_pkg::ST_FIN) begin
			unique case (statistic_select_q)
				qtds_pkg::STAT_SUM: value_q <= sum_q;
				qtds_pkg::STAT_MIN: value_q <= min_q;
				qtds_pkg::STAT_MAX: value_q <= max_q;
				default:            value_q <= '0;
			endcase
		end else if (state_q == qtds_pkg::ST_AVG_WAIT && div_done) begin
			value_q <= div_quo;
		end else if (state_q == qtds_pkg::ST_VMUL_WAIT && mul_done) begin
			value_q <= (sqsum_q > frac_val) ? (sqsum_q - frac_val) : '0;
		end else if (state_q == qtds_pkg::ST_VDIV_WAIT && div_done) begin
			value_q <= div_quo;
		end

		if (state_q == qtds_pkg::ST_RATIO_WAIT && div_done) begin
			ratio_q <= div_quo[RW-1:0];
		end

		if (state_q == qtds_pkg::ST_EMIT && out_free) begin
			value_out_q   <= value_q;
			present_out_q <= nonzero_q;
			ratio_out_q   <= ratio_q;
			sat_out_q     <= clip_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{qtds_pkg::OUT_PAD_W{1'b0}}, sat_out_q, ratio_out_q,
		present_out_q, value_out_q};

endmodule

FILE: src/qtds_checker.sv
// port-level checks on the statistics block, bound to the top level
`timescale 1ns / 1ps

module qtds_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [qtds_pkg::OUT_DATA_W-1:0]     m_tdata
);

	// a stalled result transaction holds its data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("result changed while stalled");

	// no more than the term limit can be counted as present
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[70:64] <= 7'd64)
	else $error("terms present above limit");

	// the ratio never exceeds one and is zero only with no present terms
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[87:71] <= 17'h10000)
			&& ((m_tdata[70:64] == 7'd0) == (m_tdata[87:71] == 17'd0)))
	else $error("present ratio inconsistent");

	// a new result is only produced while the input side is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
	else $error("result appeared while block idle");

endmodule

bind query_term_document_statistics qtds_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: sim/tb.sv
// testbench for the query term document statistics block: stream driver, predictor and checker
`timescale 1ns / 1ps

module tb;
	import qtds_pkg::*;

	localparam int FRAC           = FRACTION_BITS_DEF;
	localparam int MAX_TERMS      = MAX_QUERY_TERMS_DEF;
	localparam int IDLE_PCT       = 23;
	localparam int SETTLE_CYCLES  = 400;
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_TERMS    = 56;

	// codes outside the defined range of each register
	localparam logic [1:0] WMODE_SPARE    = 2'd3;
	localparam logic [2:0] STAT_SPARE_LO  = 3'd5;
	localparam logic [2:0] STAT_SPARE_HI  = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

	typedef struct {
		logic [COUNT_W-1:0]  count;
		logic [IDF_W-1:0]    idf;
		logic [LENGTH_W-1:0] length;
		logic                last;
	} term_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [TERMS_W-1:0] present;
		logic [RATIO_W-1:0] ratio;
		logic               sat;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	query_term_document_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	term_t  term_queue[$];
	stats_t expected_stats[$];
	int     queued_terms = 0;
	int     accepted_terms = 0;
	int     errors = 0;
	bit     term_taken = 1'b0;
	bit     quiet = 1'b0;
	bit     hold_req = 1'b0;
	int     hold_left = 0;
	int     stuck_cycles = 0;

	// predictor copy of the registers and per-document accumulators
	logic [1:0]         wmode = WMODE_RAW;
	logic [2:0]         stat_sel = STAT_SUM;
	logic [VALUE_W-1:0] doc_sum, doc_sq_sum, doc_min, doc_max;
	logic [TERMS_W-1:0] doc_terms, doc_nonzero;
	logic               doc_clip;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_document();
		doc_sum = '0;
		doc_sq_sum = '0;
		doc_min = '1;
		doc_max = '0;
		doc_terms = '0;
		doc_nonzero = '0;
		doc_clip = 1'b0;
	endfunction

	function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[VALUE_W]) begin
			doc_clip = 1'b1;
			return '1;
		end
		return s[VALUE_W-1:0];
	endfunction

	// fixed-point product floor(a * b >> FRAC), clipped to 64 bits
	function automatic logic [VALUE_W-1:0] frac_mul_sat(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [2*VALUE_W-1:0] p;
		p = {{VALUE_W{1'b0}}, a} * {{VALUE_W{1'b0}}, b};
		if (p[2*VALUE_W-1:VALUE_W+FRAC] != '0) begin
			doc_clip = 1'b1;
			return '1;
		end
		return p[VALUE_W+FRAC-1:FRAC];
	endfunction

	function automatic void fold_term(input logic [COUNT_W-1:0] count,
			input logic [IDF_W-1:0] idf, input logic [LENGTH_W-1:0] length, input logic last);
		logic [VALUE_W-1:0] w, n, m, sq, d, v;
		logic [31:0] ratio;
		stats_t r;
		if (doc_terms < MAX_TERMS) begin
			case (wmode)
				WMODE_LEN: w = ({48'd0, count} << FRAC) / ({40'd0, length} + 64'd1);
				WMODE_IDF: w = ({48'd0, count} * {48'd0, idf}) << (FRAC - 8);
				default:   w = {48'd0, count} << FRAC;
			endcase
			doc_sum = sat_add(doc_sum, w);
			doc_sq_sum = sat_add(doc_sq_sum, frac_mul_sat(w, w));
			if (w < doc_min)
				doc_min = w;
			if (w > doc_max)
				doc_max = w;
			doc_terms = doc_terms + 1'b1;
			if (count != '0)
				doc_nonzero = doc_nonzero + 1'b1;
		end
		if (!last)
			return;
		n = (doc_terms == '0) ? 64'd1 : {57'd0, doc_terms};
		v = '0;
		case (stat_sel)
			STAT_SUM:  v = doc_sum;
			STAT_MIN:  v = doc_min;
			STAT_MAX:  v = doc_max;
			STAT_VAR: begin
				if (n > 1) begin
					m = doc_sum / n;
					sq = frac_mul_sat(m, doc_sum);
					d = (doc_sq_sum > sq) ? doc_sq_sum - sq : '0;
					v = d / (n - 1);
				end
			end
			STAT_MEAN: v = doc_sum / n;
			default:   v = '0;
		endcase
		ratio = ({25'd0, doc_nonzero} << 16) / n[31:0];
		r.value = v;
		r.present = doc_nonzero;
		r.ratio = ratio[RATIO_W-1:0];
		r.sat = doc_clip;
		expected_stats.push_back(r);
		clear_document();
	endfunction

	initial clear_document();

	// input side: present queued terms, idling at random
	always @(negedge clk) begin
		term_t t;
		if (arst_n && (!s_tvalid || term_taken)) begin
			term_taken = 1'b0;
			if (term_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				t = term_queue.pop_front();
				s_tdata <= {t.length, t.idf, t.count};
				s_tlast <= t.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			fold_term(s_tdata[15:0], s_tdata[31:16], s_tdata[55:32], s_tlast);
			accepted_terms = accepted_terms + 1;
			term_taken = 1'b1;
		end
	end

	// output side: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			errors = errors + 1;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		stats_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_stats.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
			end else begin
				r = expected_stats.pop_front();
				check_field("statistic_value", r.value, m_tdata[63:0]);
				check_field("terms_present", {57'd0, r.present}, {57'd0, m_tdata[70:64]});
				check_field("present_ratio", {47'd0, r.ratio}, {47'd0, m_tdata[87:71]});
				check_field("saturated", {63'd0, r.sat}, {63'd0, m_tdata[88]});
				check_field("pad", 64'd0, {57'd0, m_tdata[95:89]});
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stuck_cycles = 0;
			else
				stuck_cycles = stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic add_term(input logic [COUNT_W-1:0] count, input logic [IDF_W-1:0] idf,
			input logic [LENGTH_W-1:0] length, input logic last);
		term_t t;
		t.count = count;
		t.idf = idf;
		t.length = length;
		t.last = last;
		term_queue.push_back(t);
		queued_terms = queued_terms + 1;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(accepted_terms == queued_terms && expected_stats.size() == 0));
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_WEIGHTING_MODE)
			wmode = data[1:0];
		else if (idx == CFG_STATISTIC_SELECT)
			stat_sel = data[2:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// upper data bits are don't-care; scramble fills them with noise
	task automatic set_config(input logic [1:0] mode, input logic [2:0] stat, input bit scramble);
		logic [CFG_DATA_W-1:0] junk;
		wait_idle();
		junk = scramble ? CFG_DATA_W'($urandom) : '0;
		cfg_write(CFG_WEIGHTING_MODE, (junk & 8'hFC) | {6'd0, mode});
		cfg_write(CFG_STATISTIC_SELECT, (junk & 8'hF8) | {5'd0, stat});
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(9))
			0, 1:    return '0;
			2:       return '1;
			3:       return 16'd1;
			4, 5:    return COUNT_W'($urandom_range(2, 15));
			default: return COUNT_W'($urandom);
		endcase
	endfunction

	function automatic logic [IDF_W-1:0] pick_idf();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return IDF_W'($urandom_range(1, 1024));
			default: return IDF_W'($urandom);
		endcase
	endfunction

	function automatic logic [LENGTH_W-1:0] pick_length();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return LENGTH_W'($urandom_range(1, 200));
			default: return LENGTH_W'($urandom);
		endcase
	endfunction

	// one document of random terms; returns how many terms it holds
	task automatic add_document(output int n);
		int r;
		logic [LENGTH_W-1:0] length;
		bit ragged;
		r = $urandom_range(99);
		if (r < 60)
			n = $urandom_range(1, 4);
		else if (r < 85)
			n = $urandom_range(5, 16);
		else if (r < 95)
			n = $urandom_range(17, MAX_TERMS);
		else
			n = $urandom_range(MAX_TERMS, MAX_TERMS + 6);
		length = pick_length();
		// a few documents change length between terms
		ragged = ($urandom_range(9) == 0);
		for (int i = 0; i < n; i++)
			add_term(pick_count(), pick_idf(), ragged ? pick_length() : length, i == n - 1);
	endtask

	initial begin
		int n, phase_items;
		logic [1:0] mode;
		logic [2:0] stat;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: raw sum
		add_term('1, '1, '1, 1'b0);
		add_term('0, '0, '0, 1'b1);
		set_config(WMODE_LEN, STAT_MIN, 1'b0);
		add_term('1, '0, '0, 1'b0);
		add_term(16'd1, 16'd1, '1, 1'b0);
		add_term(16'd7, 16'd3, 24'd10, 1'b1);
		set_config(WMODE_IDF, STAT_MAX, 1'b0);
		add_term('1, '1, 24'd5, 1'b0);
		add_term(16'd1, 16'd1, 24'd5, 1'b1);
		// largest idf weights clip the sum of squares; then a one-term variance
		set_config(WMODE_IDF, STAT_VAR, 1'b0);
		add_term('1, '1, '0, 1'b0);
		add_term('1, '1, '0, 1'b1);
		add_term(16'd5, 16'd100, 24'd3, 1'b1);
		set_config(WMODE_SPARE, STAT_MEAN, 1'b0);
		add_term(16'd3, '0, 24'd1, 1'b0);
		add_term(16'd4, '0, 24'd1, 1'b0);
		add_term('0, '0, 24'd1, 1'b1);
		set_config(WMODE_RAW, STAT_SPARE_LO, 1'b0);
		add_term(16'd9, 16'd2, 24'd1, 1'b1);
		set_config(WMODE_LEN, STAT_SPARE_HI, 1'b0);
		add_term(16'd2, 16'd2, 24'd2, 1'b0);
		add_term('0, '0, 24'd2, 1'b1);
		wait_idle();
		cfg_write(CFG_UNUSED_LO, '1);
		cfg_write(CFG_UNUSED_HI, '1);
		set_config(WMODE_RAW, STAT_VAR, 1'b0);
		add_term(16'd1, '0, '0, 1'b0);
		add_term(16'd3, '0, '0, 1'b0);
		add_term(16'd8, '0, '0, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin mode = WMODE_RAW;   stat = STAT_SUM;      end
				1: begin mode = WMODE_IDF;   stat = STAT_MEAN;     end
				2: begin mode = WMODE_LEN;   stat = STAT_VAR;      end
				3: begin mode = WMODE_SPARE; stat = STAT_MAX;      end
				4: begin mode = WMODE_RAW;   stat = STAT_MIN;      end
				5: begin mode = WMODE_LEN;   stat = STAT_SPARE_HI; end
				default: begin
					mode = 2'($urandom_range(0, 3));
					stat = ($urandom_range(9) > 7) ? 3'($urandom_range(5, 7))
						: 3'($urandom_range(0, 4));
				end
			endcase
			set_config(mode, stat, p[0]);
			quiet = (p == 0);
			phase_items = 0;
			if (p == 4) begin
				// output held off while short documents keep coming
				hold_req = 1'b1;
				for (int i = 0; i < 30; i++)
					add_term(pick_count(), pick_idf(), pick_length(), 1'b1);
				phase_items = 30;
			end
			while (phase_items < PHASE_TERMS) begin
				add_document(n);
				phase_items = phase_items + n;
			end
			wait_idle();
			quiet = 1'b0;
		end

		wait_idle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
src/qtds_pkg.sv
src/qtds_div.sv
src/qtds_mul.sv
src/query_term_document_statistics.sv
src/qtds_checker.sv
sim/tb.sv
